/* rtl/plt_pkg.sv */
`timescale 1ns / 1ps

package plt_pkg;

  // Item opcodes carried in the mode field.
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_MAP    = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_CHUNK_START = 1'b0;
  localparam logic CFG_CHUNK_END   = 1'b1;

  localparam int TIME_W  = 48;
  localparam int KEY_W   = 32;
  localparam int ORIG_W  = 31;
  localparam int QUOT_W  = 32;
  localparam int DIVD_W  = 63;
  localparam int SCALE_W = 14;
  localparam int PROD_W  = ORIG_W + SCALE_W;

  // Centiseconds to microseconds.
  localparam logic [SCALE_W-1:0] US_PER_CS = 14'd10000;

  // One breakpoint of the table.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [ORIG_W-1:0]       orig;
  } entry_t;

endpackage

/* rtl/piecewise_linear_time_remap.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall  in_mode, in_processed_time, in_original_time
// out_      output     out_valid/out_stall  out_mapped_time
// cfg_      input      cfg_we               cfg_index, cfg_data
//
// Append, clear and unused-mode words are taken without leaving the idle state.
// A map word reads the breakpoint table one entry a cycle through the
// table's single read port, first entry first, until its segment is found.
// An interpolated map then loads the restoring divider and waits for its
// quotient, and every map but a negative query passes through a scaling
// and a clamping state; all maps end in the output state.
// Reset is synchronous and active low; it empties the table and restores
// the chunk registers. The table contents themselves are not cleared.
// While a result word waits under out_stall the block still accepts the
// next input word, but a further map result waits until the first is taken.

module piecewise_linear_time_remap
  import plt_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_mode,
  input  logic signed [KEY_W-1:0]  in_processed_time,
  input  logic [ORIG_W-1:0]        in_original_time,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [TIME_W-1:0]        out_mapped_time,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [TIME_W-1:0]        cfg_data
);

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_SCALE,
    S_ADD,
    S_OUT
  } state_t;

  state_t state_r;

  logic [TIME_W-1:0]       chunk_start_r;
  logic [TIME_W-1:0]       chunk_end_r;
  logic [CNT_W-1:0]        count_r;
  logic signed [KEY_W-1:0] last_key_r;
  logic signed [KEY_W-1:0] q_r;
  entry_t                  prev_r;
  logic [ADDR_W-1:0]       idx_r;
  logic [QUOT_W-1:0]       a_r;
  logic [QUOT_W-1:0]       span_r;
  logic [ORIG_W-1:0]       absd_r;
  logic                    neg_r;
  logic [ORIG_W-1:0]       v_r;
  logic [PROD_W-1:0]       scaled_r;
  logic [TIME_W-1:0]       res_r;
  logic                    out_valid_r;
  logic [TIME_W-1:0]       out_time_r;

  logic                    accept;
  logic                    tbl_we;
  logic [ADDR_W-1:0]       tbl_waddr;
  entry_t                  tbl_wentry;
  logic [ADDR_W-1:0]       tbl_raddr;
  entry_t                  rd;

  logic                    div_start;
  logic                    div_done;
  logic [DIVD_W-1:0]       div_dividend;
  logic [QUOT_W-1:0]       quot;

  logic signed [KEY_W:0]   span_full;
  logic [KEY_W:0]          a_full;
  logic [ORIG_W:0]         d_full;
  logic [ORIG_W:0]         v_full;
  logic [TIME_W:0]         sum_full;
  logic                    last_entry;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  // Table writes come only from append words; the last key is mirrored in
  // a register so that the overwrite test needs no table read.
  always_comb begin
    tbl_we            = 1'b0;
    tbl_waddr         = ADDR_W'(count_r);
    tbl_wentry.key    = in_processed_time;
    tbl_wentry.orig   = in_original_time;
    if (accept && in_mode == MODE_APPEND) begin
      if (count_r != '0 && last_key_r == in_processed_time) begin
        tbl_we    = 1'b1;
        tbl_waddr = ADDR_W'(count_r - CNT_W'(1));
      end else if (count_r < CNT_W'(MAX_POINTS)) begin
        tbl_we = 1'b1;
      end
    end
  end

  // The read address runs one entry ahead of the entry being compared.
  always_comb begin
    unique case (state_r)
      S_FIRST: tbl_raddr = ADDR_W'(1);
      S_SCAN:  tbl_raddr = idx_r + ADDR_W'(1);
      default: tbl_raddr = '0;
    endcase
  end

  plt_table #(
    .DEPTH  (MAX_POINTS),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk    (clk),
    .we     (tbl_we),
    .waddr  (tbl_waddr),
    .wentry (tbl_wentry),
    .raddr  (tbl_raddr),
    .rentry (rd)
  );

  // The product of the offset into the segment and the magnitude of the
  // original-time step is loaded straight into the divider's register.
  assign div_start    = (state_r == S_MUL);
  assign div_dividend = DIVD_W'(a_r) * DIVD_W'(absd_r);

  plt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (span_r),
    .done     (div_done),
    .quotient (quot)
  );

  // Segment arithmetic. The query lies strictly above the segment start, so
  // the offset is positive and never larger than the span, and the
  // interpolated value stays between the two original times.
  always_comb begin
    span_full  = $signed({rd.key[KEY_W-1], rd.key}) -
                 $signed({prev_r.key[KEY_W-1], prev_r.key});
    a_full     = {q_r[KEY_W-1], q_r} - {prev_r.key[KEY_W-1], prev_r.key};
    d_full     = {1'b0, rd.orig} - {1'b0, prev_r.orig};
    v_full     = neg_r ? ({1'b0, prev_r.orig} - {1'b0, quot[ORIG_W-1:0]})
                       : ({1'b0, prev_r.orig} + {1'b0, quot[ORIG_W-1:0]});
    sum_full   = {1'b0, chunk_start_r} + (TIME_W + 1)'(scaled_r);
    last_entry = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      chunk_start_r <= '0;
      chunk_end_r   <= '1;
      out_valid_r   <= 1'b0;
    end else begin
      // The output state reloads the result register itself.
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CHUNK_START: chunk_start_r <= cfg_data;
          CFG_CHUNK_END:   chunk_end_r   <= cfg_data;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_mode)
              MODE_APPEND: begin
                if (tbl_we && tbl_waddr == ADDR_W'(count_r) &&
                    !(count_r != '0 && last_key_r == in_processed_time)) begin
                  count_r    <= count_r + CNT_W'(1);
                  last_key_r <= in_processed_time;
                end
              end
              MODE_MAP: begin
                q_r <= in_processed_time;
                if (in_processed_time < 0) begin
                  // A negative query maps to the chunk start.
                  res_r   <= chunk_start_r;
                  state_r <= S_OUT;
                end else if (count_r == '0) begin
                  // An empty table passes the time through.
                  v_r     <= in_processed_time[ORIG_W-1:0];
                  state_r <= S_SCALE;
                end else begin
                  state_r <= S_FIRST;
                end
              end
              MODE_CLEAR: count_r <= '0;
              default: ;
            endcase
          end
        end

        S_FIRST: begin
          // The first entry clamps queries at or below it, and a single
          // entry clamps everything above it too.
          if (q_r <= rd.key || count_r == CNT_W'(1)) begin
            v_r     <= rd.orig;
            state_r <= S_SCALE;
          end else begin
            prev_r  <= rd;
            idx_r   <= ADDR_W'(1);
            state_r <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (q_r > rd.key) begin
            if (last_entry) begin
              v_r     <= rd.orig;
              state_r <= S_SCALE;
            end else begin
              prev_r <= rd;
              idx_r  <= idx_r + ADDR_W'(1);
            end
          end else if (span_full[KEY_W] || span_full == '0) begin
            // A flat or reversed segment yields its end point.
            v_r     <= rd.orig;
            state_r <= S_SCALE;
          end else begin
            a_r     <= a_full[QUOT_W-1:0];
            span_r  <= span_full[QUOT_W-1:0];
            neg_r   <= d_full[ORIG_W];
            absd_r  <= d_full[ORIG_W] ? ORIG_W'(-d_full) : d_full[ORIG_W-1:0];
            state_r <= S_MUL;
          end
        end

        S_MUL: state_r <= S_DIV;

        S_DIV: begin
          if (div_done) begin
            v_r     <= v_full[ORIG_W-1:0];
            state_r <= S_SCALE;
          end
        end

        S_SCALE: begin
          scaled_r <= PROD_W'(v_r) * PROD_W'(US_PER_CS);
          state_r  <= S_ADD;
        end

        S_ADD: begin
          // The scaled value is never negative, so only the upper clamp
          // can apply after the offset is added.
          if (sum_full > {1'b0, chunk_end_r}) begin
            res_r <= chunk_end_r;
          end else begin
            res_r <= sum_full[TIME_W-1:0];
          end
          state_r <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_time_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mapped_time = out_time_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("breakpoint count exceeds table depth");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_neg_query: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == MODE_MAP && in_processed_time < 0
    |=> state_r == S_OUT && res_r == $past(chunk_start_r))
    else $error("negative query did not map to the chunk start");

  a_first_append: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == MODE_APPEND && count_r == '0 |=> count_r == CNT_W'(1))
    else $error("append to an empty table did not add an entry");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> CNT_W'(idx_r) < count_r)
    else $error("scan index ran past the filled entries");

endmodule

/* rtl/plt_table.sv */
`timescale 1ns / 1ps

module plt_table
  import plt_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wentry,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rentry
);

  entry_t mem [DEPTH];
  entry_t rentry_r;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wentry;
    end
    rentry_r <= mem[raddr];
  end

  assign rentry = rentry_r;

endmodule

/* rtl/plt_div.sv */
`timescale 1ns / 1ps

module plt_div
  import plt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [QUOT_W-1:0] divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quotient
);

  // Restoring division, one quotient bit a cycle. The caller guarantees
  // that the quotient fits in QUOT_W bits, so the upper dividend bits
  // start out below the divisor.
  logic [2*QUOT_W-1:0] acc_r, acc_nxt;
  logic [QUOT_W-1:0]   dvs_r;
  logic [4:0]          cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [2*QUOT_W:0]   shifted;
  logic [QUOT_W:0]     trial;
  logic                fits;

  always_comb begin
    shifted = {acc_r, 1'b0};
    fits    = shifted[2*QUOT_W:QUOT_W] >= {1'b0, dvs_r};
    trial   = fits ? (shifted[2*QUOT_W:QUOT_W] - {1'b0, dvs_r})
                   : shifted[2*QUOT_W:QUOT_W];
    acc_nxt = {trial[QUOT_W-1:0], shifted[QUOT_W-1:1], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
        acc_r  <= {1'b0, dividend};
        dvs_r  <= divisor;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = acc_r[QUOT_W-1:0];

endmodule

/* dv/tb_piecewise_linear_time_remap.sv */
`timescale 1ns / 1ps

// The block keeps a table of breakpoints, each pairing a processed time with
// an original time, and maps processed times back to original time in
// microseconds. This bench keeps its own copy of that table and of the chunk
// registers, predicts the mapped time of every map word at the moment the
// block takes the word, and checks each result word against the oldest
// prediction still waiting.

module tb_piecewise_linear_time_remap;
  import plt_pkg::*;

  localparam int MAX_POINTS = 64;

  // Mode 3 has no meaning to the block, so the package gives it no name.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic [ORIG_W-1:0] ORIG_MAX = 31'h7fff_ffff;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam longint KEY_HI = 64'sd2147483647;
  localparam longint KEY_LO = -64'sd2147483648;

  // Interpolated values are saturated at 2^48 centiseconds either way.
  localparam longint SAT_CS = 64'sd281474976710656;

  // A map word can scan the whole table, wait out the divider and then
  // scale and clamp before its result. The drain wait covers that with margin.
  localparam int DRAIN_CYCLES = 160;
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [KEY_W-1:0] key;
    logic [ORIG_W-1:0]       orig;
  } word_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_mode = MODE_APPEND;
  logic signed [KEY_W-1:0] in_processed_time = '0;
  logic [ORIG_W-1:0]       in_original_time = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [TIME_W-1:0]       out_mapped_time;
  logic                    cfg_we = 1'b0;
  logic                    cfg_index = CFG_CHUNK_START;
  logic [TIME_W-1:0]       cfg_data = '0;

  piecewise_linear_time_remap #(
    .MAX_POINTS(MAX_POINTS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_processed_time(in_processed_time),
    .in_original_time (in_original_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mapped_time  (out_mapped_time),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the breakpoint table and the chunk registers. It changes
  // only when the block takes a word or a register is written.
  logic signed [KEY_W-1:0] bp_key [MAX_POINTS];
  logic [ORIG_W-1:0]       bp_orig [MAX_POINTS];
  int                      bp_count = 0;
  logic [TIME_W-1:0]       chunk_start_q = '0;
  logic [TIME_W-1:0]       chunk_end_q = TIME_MAX;

  word_t             words_to_send [$];
  logic [TIME_W-1:0] mapped_times_due [$];
  longint            curve_keys [$];
  word_t             word_on_bus;
  logic [TIME_W-1:0] due_time;
  int                counted_words = 0;
  int                idle_pct = 15;
  int                send_gap = 0;
  int                stall_left = 0;
  int                hold_left = 0;
  int                hold_requests = 0;
  int                hold_served = 0;
  int                quiet_cycles = 0;
  int                error_count = 0;

  function automatic int rand_pct();
    return $urandom_range(0, 99);
  endfunction

  function automatic logic signed [KEY_W-1:0] rand_key();
    return $urandom();
  endfunction

  function automatic logic [ORIG_W-1:0] rand_orig();
    logic [31:0] r;
    r = $urandom();
    return r[ORIG_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TIME_W-1:0];
  endfunction

  // Original time in centiseconds for a non-negative query. The first
  // segment whose end key is not below the query is used; the division
  // truncates toward zero just as the hardware divider does.
  function automatic longint interp_cs(longint q);
    longint p0, p1, o0, o1, span, quot, v;
    bit     found;
    found = 1'b0;
    if (bp_count == 0) return q;
    if (q <= longint'(bp_key[0])) return longint'(bp_orig[0]);
    v = longint'(bp_orig[bp_count-1]);
    for (int i = 1; i < bp_count; i++) begin
      if (!found && q <= longint'(bp_key[i])) begin
        found = 1'b1;
        p0 = longint'(bp_key[i-1]);
        p1 = longint'(bp_key[i]);
        o0 = longint'(bp_orig[i-1]);
        o1 = longint'(bp_orig[i]);
        span = p1 - p0;
        if (span <= 0) begin
          v = o1;
        end else begin
          quot = ((q - p0) * (o1 - o0)) / span;
          if (quot > SAT_CS) v = SAT_CS;
          else if (quot < -SAT_CS) v = -SAT_CS;
          else v = o0 + quot;
        end
      end
    end
    return v;
  endfunction

  // Mapped time in microseconds, offset by the chunk start and clamped to
  // the chunk, lower bound first.
  function automatic logic [TIME_W-1:0] remap_us(logic signed [KEY_W-1:0] q);
    longint      v;
    logic [63:0] x;
    if (q < 0) return chunk_start_q;
    v = interp_cs(longint'(q));
    if (v < 0) return chunk_start_q;
    if (v >= SAT_CS) return chunk_end_q;
    x = 64'(chunk_start_q) + 64'(v) * 64'(US_PER_CS);
    if (x > 64'(chunk_end_q)) return chunk_end_q;
    return x[TIME_W-1:0];
  endfunction

  // Update the shadow table for a word the block has just taken. A map
  // word leaves its predicted time in the queue of results due.
  task automatic apply_word_to_table(word_t w);
    case (w.mode)
      MODE_APPEND: begin
        if (bp_count > 0 && bp_key[bp_count-1] == w.key) begin
          bp_orig[bp_count-1] = w.orig;
        end else if (bp_count < MAX_POINTS) begin
          bp_key[bp_count] = w.key;
          bp_orig[bp_count] = w.orig;
          bp_count++;
        end
      end
      MODE_MAP: mapped_times_due = {mapped_times_due, remap_us(w.key)};
      MODE_CLEAR: bp_count = 0;
      default: ;
    endcase
  endtask

  task automatic queue_word(logic [1:0] mode, logic signed [KEY_W-1:0] key,
                            logic [ORIG_W-1:0] orig);
    word_t w;
    w.mode = mode;
    w.key = key;
    w.orig = orig;
    words_to_send = {words_to_send, w};
    if (mode != MODE_UNUSED) counted_words++;
  endtask

  // A well-formed curve: clear, append n_pts breakpoints, then query it.
  // Ordered curves climb in key with the odd repeated key, which turns into
  // an overwrite; unordered ones use keys from the whole range.
  task automatic queue_curve(int n_pts, bit ordered);
    longint key, orig, lo_key, hi_key, q;
    int     n_maps, pick;
    curve_keys.delete();
    queue_word(MODE_CLEAR, rand_key(), rand_orig());
    if (rand_pct() < 20) key = KEY_HI - longint'(n_pts) * 3000;
    else key = longint'($urandom_range(0, 400000)) - 2000;
    orig = longint'($urandom_range(0, 1000000));
    for (int i = 0; i < n_pts; i++) begin
      if (!ordered) key = longint'(rand_key());
      if (curve_keys.size() == 0 || curve_keys[$] != key) curve_keys = {curve_keys, key};
      queue_word(MODE_APPEND, key[KEY_W-1:0], orig[ORIG_W-1:0]);
      if (ordered) begin
        if (n_pts <= MAX_POINTS && rand_pct() < 10) key = key;
        else key = key + longint'($urandom_range(1, 3000));
        if (key > KEY_HI) key = KEY_HI;
      end
      if (rand_pct() < 30) orig = longint'(rand_orig());
      else orig = orig + longint'($urandom_range(0, 20000));
      if (orig > longint'(ORIG_MAX)) orig = longint'(ORIG_MAX);
    end
    // Once the table is full, a new key is dropped but rewriting the last
    // point must still take effect.
    if (n_pts > MAX_POINTS && curve_keys.size() > MAX_POINTS) begin
      q = curve_keys[MAX_POINTS-1];
      queue_word(MODE_APPEND, q[KEY_W-1:0], rand_orig());
    end
    lo_key = curve_keys[0];
    hi_key = curve_keys[$];
    n_maps = $urandom_range(2, 8);
    for (int m = 0; m < n_maps; m++) begin
      pick = rand_pct();
      if (pick < 30) q = curve_keys[$urandom_range(0, curve_keys.size() - 1)];
      else if (pick < 75 && hi_key > lo_key)
        q = lo_key + longint'($urandom_range(0, 32'(hi_key - lo_key)));
      else if (pick < 85) q = hi_key + longint'($urandom_range(1, 1000));
      else if (pick < 90) q = lo_key - 1;
      else q = longint'(rand_key());
      if (q > KEY_HI) q = KEY_HI;
      if (q < KEY_LO) q = KEY_LO;
      queue_word(MODE_MAP, q[KEY_W-1:0], rand_orig());
    end
  endtask

  // Mostly curves with random content, the rest loose words and noise.
  task automatic queue_random_batch(int n);
    int target, r;
    target = counted_words + n;
    while (counted_words < target) begin
      r = rand_pct();
      if (r < 6) queue_word(MODE_CLEAR, rand_key(), rand_orig());
      else if (r < 10) queue_word(MODE_UNUSED, rand_key(), rand_orig());
      else if (r < 18) queue_word(MODE_APPEND, rand_key(), rand_orig());
      else if (r < 30) queue_word(MODE_MAP, rand_key(), rand_orig());
      else if (r < 34) queue_curve($urandom_range(60, 70), 1'b1);
      else if (r < 42) queue_curve($urandom_range(2, 8), 1'b0);
      else queue_curve($urandom_range(1, 12), 1'b1);
    end
  endtask

  // Sampled on the falling edge so that the driver's work at the rising
  // edge has fully settled. A word that causes no result may still be in
  // the block when the last result leaves, hence the extra cycles.
  task automatic wait_until_drained();
    @(negedge clk);
    while (words_to_send.size() != 0 || in_valid || mapped_times_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_chunk(logic [TIME_W-1:0] from_us, logic [TIME_W-1:0] to_us);
    wait_until_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHUNK_START;
    cfg_data <= from_us;
    @(posedge clk);
    cfg_index <= CFG_CHUNK_END;
    cfg_data <= to_us;
    @(posedge clk);
    cfg_we <= 1'b0;
    chunk_start_q = from_us;
    chunk_end_q = to_us;
  endtask

  task automatic report_error(string what, logic [TIME_W-1:0] want,
                              logic [TIME_W-1:0] got);
    error_count++;
    if (error_count <= 10)
      $display("ERROR %s: mapped_time expected %0d, got %0d", what, want, got);
  endtask

  // Driver. When the bus is free it either starts a short idle burst or
  // presents the next word. A presented word stays put until it is taken;
  // the decision to idle never looks at in_stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_word_to_table(word_on_bus);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (idle_pct > 0 && rand_pct() < idle_pct) begin
          send_gap <= $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          word_on_bus = words_to_send.pop_front();
          in_mode <= word_on_bus.mode;
          in_processed_time <= word_on_bus.key;
          in_original_time <= word_on_bus.orig;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result-side back-pressure. A requested long hold takes priority and is
  // counted here; otherwise short random bursts drawn through stall_left.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_pct > 0 && rand_pct() < idle_pct) begin
      stall_left <= $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor. Every result word taken is matched against the oldest
  // prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (mapped_times_due.size() == 0) begin
        report_error("result with no map word pending", '0, out_mapped_time);
      end else begin
        due_time = mapped_times_due.pop_front();
        if (out_mapped_time !== due_time)
          report_error("mapped_time mismatch", due_time, out_mapped_time);
      end
    end
  end

  // Counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0] s;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words, with the chunk registers still at their reset values.
    // With an empty table the query passes straight through, at both ends
    // of the non-negative range.
    queue_word(MODE_MAP, 32'sd0, ORIG_MAX);
    queue_word(MODE_MAP, KEY_MAX, '0);
    // Negative queries always land on the chunk start.
    queue_word(MODE_MAP, -32'sd1, '0);
    queue_word(MODE_MAP, KEY_MIN, '0);
    // Mode 3 must be swallowed without a result or a change to the table.
    queue_word(MODE_UNUSED, KEY_MAX, ORIG_MAX);
    // A single breakpoint: at its key and past it.
    queue_word(MODE_APPEND, 32'sd100, 31'd500);
    queue_word(MODE_MAP, 32'sd100, '0);
    queue_word(MODE_MAP, 32'sd5000, '0);
    // Same key again rewrites the last point; then a higher key, a descending
    // key and the largest key, with the widest original times.
    queue_word(MODE_APPEND, 32'sd100, 31'd700);
    queue_word(MODE_APPEND, 32'sd300, ORIG_MAX);
    queue_word(MODE_APPEND, 32'sd200, 31'd40);
    queue_word(MODE_APPEND, KEY_MAX, '0);
    // Below the first key, on it, inside the first segment, just below its end
    // and on it, in a later segment, and on the last key.
    queue_word(MODE_MAP, 32'sd50, '0);
    queue_word(MODE_MAP, 32'sd100, '0);
    queue_word(MODE_MAP, 32'sd250, '0);
    queue_word(MODE_MAP, 32'sd299, '0);
    queue_word(MODE_MAP, 32'sd300, '0);
    queue_word(MODE_MAP, 32'sd1000, '0);
    queue_word(MODE_MAP, KEY_MAX, ORIG_MAX);
    // Clear empties the table, so the next query passes through again.
    queue_word(MODE_CLEAR, KEY_MIN, ORIG_MAX);
    queue_word(MODE_MAP, 32'sd77, '0);
    // A lone point at the most negative key: any non-negative query is past the end.
    queue_word(MODE_APPEND, KEY_MIN, '0);
    queue_word(MODE_MAP, 32'sd5, '0);
    queue_word(MODE_CLEAR, '0, '0);

    // Widest chunk, written explicitly.
    program_chunk('0, TIME_MAX);
    queue_random_batch(24);

    // Chunk start at its top: every mapped time collapses onto a bound.
    // A full table with a trailing overwrite is forced here.
    program_chunk(TIME_MAX, TIME_MAX);
    queue_curve(68, 1'b1);
    queue_random_batch(16);

    // Start above end. The receiver also holds off for a long stretch while
    // the sender keeps going, so the block backs up and stalls its input.
    program_chunk(TIME_MAX, '0);
    hold_requests++;
    queue_random_batch(24);

    // Zero-width chunk at zero, with no idling on either side.
    idle_pct = 0;
    program_chunk('0, '0);
    queue_random_batch(16);

    idle_pct = 25;
    s = rand_time();
    program_chunk({12'd0, s[35:0]}, rand_time());
    queue_curve($urandom_range(2, 8), 1'b0);
    queue_random_batch(24);

    idle_pct = 10;
    program_chunk(rand_time(), rand_time());
    queue_random_batch(24);

    // A narrow window that clamps most results from both sides.
    idle_pct = 30;
    s = rand_time() >> 16;
    program_chunk(s, s + (rand_time() >> 12));
    queue_random_batch(24);

    // Last stretch runs flat out.
    idle_pct = 0;
    program_chunk('0, TIME_MAX);
    queue_random_batch(16);

    wait_until_drained();
    if (error_count == 0 && mapped_times_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
